// ===== src/plff_pkg.sv =====
package plff_pkg;

    localparam int PAD_COUNT_DEF = 8;
    localparam logic [15:0] FRAME_INTERVAL_RST = 16'd16;
    localparam logic [23:0] REST_COLOR_RST = 24'h1E1E1E;
    localparam logic [7:0] LEVEL_RST = 8'd255;
    localparam logic [15:0] FADE_MS_RST = 16'd200;

    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_FLASH = 2'd1;
    localparam logic [1:0] MODE_IDLE = 2'd2;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_FLASH = 2'd1;
    localparam logic [1:0] PH_FADE = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] pad;
        logic [23:0] color;
        logic [7:0] level;
        logic [15:0] fade_ms;
        logic [31:0] now_ms;
    } in_word_t;

    typedef struct packed {
        logic [5:0] led_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic refresh;
        logic final_res;
    } out_word_t;

    // Per-pad memory entry.
    typedef struct packed {
        logic [1:0] phase;
        logic [23:0] shown;
        logic [23:0] target;
        logic [23:0] rest;
        logic [7:0] level;
        logic [15:0] fade_ms;
        logic [31:0] start_ms;
    } pad_entry_t;

    localparam pad_entry_t PAD_RST = '{
        phase: PH_IDLE, shown: 24'h0, target: 24'h0, rest: REST_COLOR_RST,
        level: LEVEL_RST, fade_ms: FADE_MS_RST, start_ms: 32'h0};

    // (c * (lv + 1)) >> 8
    function automatic logic [7:0] scale8(input logic [7:0] c, input logic [7:0] lv);
        logic [16:0] p;
        p = {9'd0, c} * ({9'd0, lv} + 17'd1);
        return p[15:8];
    endfunction

endpackage

// ===== src/pad_led_flash_fade.sv =====
// Flash and set-idle words: the pad entry is read and written back, then the result word
// is loaded when the output is free; a set-idle word on a busy pad gives no result word.
// A tick word whose interval has passed walks every pad: a pad at rest or flashing is
// checked, a fading pad also goes through a restoring divider, then the channel blends;
// then every pad is emitted, with output stalls; one word is processed at a time.
// Reset: asynchronous; a clearing pass then writes PAD_COUNT entries, one per cycle,
// before the first word is accepted; the interval register resets to 16.
module pad_led_flash_fade
    import plff_pkg::*;
#(
    parameter int PAD_COUNT = PAD_COUNT_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  in_word_t in_data,
    output logic out_valid,
    input  logic out_stall,
    output out_word_t out_data,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam int AW = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
    localparam int CW = $clog2(PAD_COUNT + 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_PAD, S_TRD, S_TCHK, S_DIV, S_MIX,
        S_MIXW, S_ORD, S_OUT, S_EMIT_RD, S_EMIT
    } state_t;

    pad_entry_t mem [PAD_COUNT];
    pad_entry_t rd_reg;
    pad_entry_t ent_reg;

    state_t state_reg;
    in_word_t item_reg;
    logic [15:0] interval_reg;
    logic [31:0] last_tick_reg;
    logic [CW-1:0] idx_reg;
    logic busy_reg;
    logic tick_reg;
    logic [AW-1:0] rd_addr;
    logic wr_en;
    logic [AW-1:0] wr_addr;
    pad_entry_t wr_data;
    logic [16:0] rem_reg;
    logic [23:0] div_reg;
    logic [7:0] quo_reg;
    logic [5:0] cnt_reg;
    logic [1:0] ch_reg;
    logic [7:0] t_reg;
    logic [16:0] mix_reg;
    out_word_t out_reg;
    logic out_valid_reg;
    logic out_load;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    assign cfg_ready = 1'b1;
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;
    assign out_load = ((state_reg == S_OUT && !tick_reg) || state_reg == S_EMIT)
                      && (!out_valid_reg || !out_stall);

    logic [31:0] tchk_el;
    logic [23:0] dividend;
    logic [16:0] div_shift;
    logic [17:0] div_trial;
    logic [7:0] ca, cb;
    logic [16:0] mix_sum;
    logic [8:0] mix_q;

    always_comb
    begin
        tchk_el = item_reg.now_ms - rd_reg.start_ms;
        // elapsed*255; elapsed is below the fade time here, so 16 bits carry it.
        dividend = {tchk_el[15:0], 8'd0} - {8'd0, tchk_el[15:0]};
        div_shift = {rem_reg[15:0], div_reg[23]};
        div_trial = {1'b0, div_shift} - {2'b00, ent_reg.fade_ms};
        case (ch_reg)
            2'd0: begin ca = ent_reg.shown[23:16]; cb = ent_reg.target[23:16]; end
            2'd1: begin ca = ent_reg.shown[15:8]; cb = ent_reg.target[15:8]; end
            default: begin ca = ent_reg.shown[7:0]; cb = ent_reg.target[7:0]; end
        endcase
        mix_sum = {9'd0, ca} * {9'd0, 8'd255 - t_reg} + {9'd0, cb} * {9'd0, t_reg};
        // x/255 for x < 65536: ((x + 1) * 257) >> 16 is exact.
        mix_q = 9'(((33'(mix_reg) + 33'd1) * 33'd257) >> 16);
    end

    function automatic out_word_t mk_out(input pad_entry_t e, input logic [5:0] i,
                                         input logic r, input logic f);
        out_word_t o;
        o.led_index = i;
        o.red = scale8(e.shown[23:16], e.level);
        o.green = scale8(e.shown[15:8], e.level);
        o.blue = scale8(e.shown[7:0], e.level);
        o.refresh = r;
        o.final_res = f;
        return o;
    endfunction

    always_comb
    begin
        rd_addr = idx_reg[AW-1:0];
        if (state_reg == S_RD)
        begin
            rd_addr = item_reg.pad[AW-1:0];
        end
        wr_en = 1'b0;
        wr_addr = idx_reg[AW-1:0];
        wr_data = ent_reg;
        if (state_reg == S_CLEAR)
        begin
            wr_en = 1'b1;
            wr_data = PAD_RST;
        end
        else if (state_reg == S_PAD)
        begin
            wr_addr = item_reg.pad[AW-1:0];
            wr_data = rd_reg;
            wr_en = 1'b1;
            if (item_reg.mode == MODE_FLASH)
            begin
                wr_data.shown = item_reg.color;
                wr_data.target = rd_reg.rest;
                wr_data.level = item_reg.level;
                wr_data.fade_ms = item_reg.fade_ms;
                wr_data.phase = PH_FLASH;
                wr_data.start_ms = item_reg.now_ms;
            end
            else
            begin
                wr_data.rest = item_reg.color;
                wr_data.level = item_reg.level;
                if (rd_reg.phase == PH_IDLE)
                begin
                    wr_data.shown = item_reg.color;
                end
            end
        end
        else if (state_reg == S_MIXW && ch_reg == 2'd3)
        begin
            wr_en = 1'b1;
        end
        else if (state_reg == S_TCHK)
        begin
            wr_data = rd_reg;
            if (rd_reg.phase == PH_FLASH)
            begin
                wr_en = 1'b1;
                wr_data.phase = PH_FADE;
            end
            else if (rd_reg.phase == PH_FADE && tchk_el >= {16'd0, rd_reg.fade_ms})
            begin
                wr_en = 1'b1;
                wr_data.phase = PH_IDLE;
                wr_data.shown = rd_reg.rest;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            idx_reg <= '0;
            interval_reg <= FRAME_INTERVAL_RST;
            last_tick_reg <= '0;
            busy_reg <= 1'b0;
            tick_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg <= '0;
            ch_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                interval_reg <= cfg_data;
            end
            out_valid_reg <= out_load || (out_valid_reg && out_stall);
            case (state_reg)
                S_CLEAR:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == CW'(PAD_COUNT - 1))
                    begin
                        idx_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        item_reg <= in_data;
                        if (in_data.mode == MODE_TICK)
                        begin
                            if (in_data.now_ms - last_tick_reg >= {16'd0, interval_reg})
                            begin
                                last_tick_reg <= in_data.now_ms;
                                busy_reg <= 1'b0;
                                idx_reg <= '0;
                                tick_reg <= 1'b1;
                                state_reg <= S_TRD;
                            end
                        end
                        else if ((in_data.mode == MODE_FLASH || in_data.mode == MODE_IDLE)
                                 && {1'b0, in_data.pad} < 9'(PAD_COUNT))
                        begin
                            tick_reg <= 1'b0;
                            state_reg <= S_RD;
                        end
                    end
                end
                S_RD:
                begin
                    state_reg <= S_PAD;
                end
                S_PAD:
                begin
                    // Memory written this cycle; emit from the written entry.
                    if (item_reg.mode == MODE_FLASH || rd_reg.phase == PH_IDLE)
                    begin
                        ent_reg <= wr_data;
                        busy_reg <= (item_reg.mode == MODE_FLASH);
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_TRD:
                begin
                    state_reg <= S_TCHK;
                end
                S_TCHK:
                begin
                    ent_reg <= wr_data;
                    if (rd_reg.phase == PH_FLASH || rd_reg.phase == PH_FADE)
                    begin
                        busy_reg <= 1'b1;
                    end
                    if (rd_reg.phase == PH_FADE && !wr_en)
                    begin
                        // Quotient of elapsed*255 / fade_ms, restoring, one bit a cycle.
                        rem_reg <= '0;
                        div_reg <= dividend;
                        quo_reg <= '0;
                        cnt_reg <= 6'd24;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_DIV:
                begin
                    if (cnt_reg == 6'd0)
                    begin
                        t_reg <= quo_reg;
                        ch_reg <= 2'd0;
                        state_reg <= S_MIX;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                        div_reg <= {div_reg[22:0], 1'b0};
                        if (!div_trial[17])
                        begin
                            rem_reg <= div_trial[16:0];
                            quo_reg <= {quo_reg[6:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= div_shift;
                            quo_reg <= {quo_reg[6:0], 1'b0};
                        end
                    end
                end
                S_MIX:
                begin
                    mix_reg <= mix_sum;
                    state_reg <= S_MIXW;
                end
                S_MIXW:
                begin
                    case (ch_reg)
                        2'd0: ent_reg.shown[23:16] <= mix_q[7:0];
                        2'd1: ent_reg.shown[15:8] <= mix_q[7:0];
                        default: ent_reg.shown[7:0] <= mix_q[7:0];
                    endcase
                    ch_reg <= ch_reg + 1'b1;
                    if (ch_reg == 2'd3)
                    begin
                        state_reg <= S_OUT;
                    end
                    else if (ch_reg == 2'd2)
                    begin
                        state_reg <= S_MIXW;
                    end
                    else
                    begin
                        state_reg <= S_MIX;
                    end
                end
                S_ORD:
                begin
                    state_reg <= S_TCHK;
                end
                S_OUT:
                begin
                    if (tick_reg)
                    begin
                        // Ticks emit once the whole walk is done.
                        if (idx_reg == CW'(PAD_COUNT - 1))
                        begin
                            idx_reg <= '0;
                            tick_reg <= 1'b0;
                            state_reg <= S_EMIT_RD;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                            state_reg <= S_ORD;
                        end
                    end
                    else if (out_load)
                    begin
                        out_reg <= mk_out(ent_reg, 6'(item_reg.pad), busy_reg, 1'b1);
                        state_reg <= S_IDLE;
                    end
                end
                S_EMIT_RD:
                begin
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_load)
                    begin
                        out_reg <= mk_out(rd_reg, 6'(idx_reg),
                                          busy_reg, idx_reg == CW'(PAD_COUNT - 1));
                        if (idx_reg == CW'(PAD_COUNT - 1))
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                            state_reg <= S_EMIT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    property p_stall_busy;
        @(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall;
    endproperty
    a_stall_busy: assert property (p_stall_busy) else $error("input taken while busy");

    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data));
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("stalled word changed");

    property p_flash_refresh;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !tick_reg && state_reg == S_IDLE && out_data.refresh)
            |-> out_data.final_res;
    endproperty
    a_flash_refresh: assert property (p_flash_refresh) else $error("flash word not final");

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
    import plff_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPADS = PAD_COUNT_DEF;
    localparam int CYCLE_LIMIT = 3000000;
    // A tick word walks every pad, fading pads through a long divider, so leave it room to drain.
    localparam int DRAIN_CYCLES = 800;

    class fade_scoreboard;
        out_word_t pending[$];
        int errors;
        int words_in;
        int words_out;
        logic [15:0] interval;
        logic [31:0] last_tick;
        logic [1:0] phase[NPADS];
        logic [23:0] shown[NPADS];
        logic [23:0] target[NPADS];
        logic [23:0] rest[NPADS];
        logic [7:0] lvl[NPADS];
        logic [15:0] dur[NPADS];
        logic [31:0] start[NPADS];

        function new();
            errors = 0;
            words_in = 0;
            words_out = 0;
            interval = FRAME_INTERVAL_RST;
            last_tick = '0;
            for (int p = 0; p < NPADS; p++)
            begin
                phase[p] = PH_IDLE;
                shown[p] = '0;
                target[p] = '0;
                rest[p] = REST_COLOR_RST;
                lvl[p] = LEVEL_RST;
                dur[p] = FADE_MS_RST;
                start[p] = '0;
            end
        endfunction

        function void set_interval(logic [15:0] v);
            interval = v;
        endfunction

        function logic [7:0] dim(logic [7:0] c, logic [7:0] lv);
            logic [16:0] prod;
            prod = 17'(c) * (17'(lv) + 17'd1);
            return prod[15:8];
        endfunction

        function logic [23:0] blend(logic [23:0] a, logic [23:0] b, logic [31:0] t);
            logic [23:0] mixed;
            logic [31:0] ch;
            for (int s = 0; s < 24; s += 8)
            begin
                ch = (32'(a[s +: 8]) * (32'd255 - t) + 32'(b[s +: 8]) * t) / 32'd255;
                mixed[s +: 8] = ch[7:0];
            end
            return mixed;
        endfunction

        function void push_pad(int p, logic refresh, logic last);
            out_word_t w;
            w.led_index = 6'(p);
            w.red = dim(shown[p][23:16], lvl[p]);
            w.green = dim(shown[p][15:8], lvl[p]);
            w.blue = dim(shown[p][7:0], lvl[p]);
            w.refresh = refresh;
            w.final_res = last;
            pending.push_back(w);
        endfunction

        function void note_input(in_word_t w);
            logic busy;
            logic [31:0] el;
            int p;
            words_in++;
            busy = 1'b0;
            p = int'(w.pad);
            if (w.mode == MODE_TICK)
            begin
                if (w.now_ms - last_tick < 32'(interval))
                    return;
                last_tick = w.now_ms;
                for (int i = 0; i < NPADS; i++)
                begin
                    if (phase[i] == PH_FLASH)
                    begin
                        phase[i] = PH_FADE;
                        busy = 1'b1;
                    end
                    else if (phase[i] == PH_FADE)
                    begin
                        busy = 1'b1;
                        el = w.now_ms - start[i];
                        if (el >= 32'(dur[i]))
                        begin
                            shown[i] = rest[i];
                            phase[i] = PH_IDLE;
                        end
                        else
                            shown[i] = blend(shown[i], target[i], (el * 32'd255) / 32'(dur[i]));
                    end
                end
                for (int i = 0; i < NPADS; i++)
                    push_pad(i, busy, i == NPADS - 1);
            end
            else if (w.mode == MODE_FLASH && p < NPADS)
            begin
                shown[p] = w.color;
                target[p] = rest[p];
                lvl[p] = w.level;
                dur[p] = w.fade_ms;
                phase[p] = PH_FLASH;
                start[p] = w.now_ms;
                push_pad(p, 1'b1, 1'b1);
            end
            else if (w.mode == MODE_IDLE && p < NPADS)
            begin
                rest[p] = w.color;
                lvl[p] = w.level;
                if (phase[p] == PH_IDLE)
                begin
                    shown[p] = w.color;
                    push_pad(p, 1'b0, 1'b1);
                end
            end
        endfunction

        function void check_result(out_word_t got);
            out_word_t want;
            words_out++;
            if (pending.size() == 0)
            begin
                $error("unexpected result word %h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.led_index !== want.led_index)
            begin
                $error("led_index: expected %0d, got %0d", want.led_index, got.led_index);
                errors++;
            end
            if (got.red !== want.red)
            begin
                $error("red: expected %0d, got %0d", want.red, got.red);
                errors++;
            end
            if (got.green !== want.green)
            begin
                $error("green: expected %0d, got %0d", want.green, got.green);
                errors++;
            end
            if (got.blue !== want.blue)
            begin
                $error("blue: expected %0d, got %0d", want.blue, got.blue);
                errors++;
            end
            if (got.refresh !== want.refresh)
            begin
                $error("refresh: expected %0d, got %0d", want.refresh, got.refresh);
                errors++;
            end
            if (got.final_res !== want.final_res)
            begin
                $error("final_res: expected %0d, got %0d", want.final_res, got.final_res);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_word_t in_data;
    logic out_valid;
    logic out_stall;
    out_word_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [15:0] cfg_data;

    fade_scoreboard sb;
    int cycles;
    int stall_run;
    int stall_pick;
    int cfg_writes;
    bit quiet;
    logic [31:0] clock_ms;

    pad_led_flash_fade #(.PAD_COUNT(NPADS)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("pad_led_flash_fade regression: fail");
            $finish;
        end
    end

    // Receiver: stall in runs, mostly short, now and then long.
    always @(posedge clk)
    begin
        if (stall_run > 0)
            stall_run <= stall_run - 1;
        else
        begin
            stall_pick = $urandom_range(0, 99);
            if (quiet || stall_pick < 60)
            begin
                out_stall <= 1'b0;
                stall_run <= $urandom_range(0, 8);
            end
            else if (stall_pick < 92)
            begin
                out_stall <= 1'b1;
                stall_run <= $urandom_range(0, 3);
            end
            else
            begin
                out_stall <= 1'b1;
                stall_run <= $urandom_range(10, 50);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
    end

    function automatic in_word_t make_word(logic [1:0] mode, logic [7:0] pad,
                                           logic [23:0] color, logic [7:0] level,
                                           logic [15:0] fade, logic [31:0] now);
        in_word_t w;
        w.mode = mode;
        w.pad = pad;
        w.color = color;
        w.level = level;
        w.fade_ms = fade;
        w.now_ms = now;
        return w;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send(in_word_t w);
        int g;
        in_valid <= 1'b1;
        in_data <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(w);
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic write_interval(logic [15:0] v);
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_interval(v);
        cfg_writes++;
    endtask

    task automatic tick_after(logic [31:0] delta);
        clock_ms = clock_ms + delta;
        send(make_word(MODE_TICK, 8'($urandom), 24'($urandom), 8'($urandom),
                       16'($urandom), clock_ms));
    endtask

    task automatic random_word(logic [15:0] iv);
        int r;
        logic [7:0] pad;
        logic [15:0] fade;
        r = $urandom_range(0, 99);
        pad = 8'($urandom_range(0, NPADS - 1));
        if (r < 30 || (r >= 88 && r < 94))
        begin
            if (r >= 88)
                pad = 8'($urandom_range(NPADS, 255));
            if ($urandom_range(0, 9) < 7)
                fade = 16'($urandom_range(0, 300));
            else if ($urandom_range(0, 2) == 0)
                fade = '0;
            else
                fade = 16'($urandom);
            clock_ms = clock_ms + $urandom_range(0, 5);
            send(make_word(MODE_FLASH, pad, 24'($urandom), 8'($urandom), fade, clock_ms));
        end
        else if (r < 45)
        begin
            clock_ms = clock_ms + $urandom_range(0, 5);
            send(make_word(MODE_IDLE, pad, 24'($urandom), 8'($urandom),
                           16'($urandom), clock_ms));
        end
        else if (r < 88)
        begin
            if ($urandom_range(0, 19) == 0)
                tick_after($urandom);
            else
                tick_after($urandom_range(0, 2 * int'(iv) + 40));
        end
        else
            send(make_word(2'd3, 8'($urandom), 24'($urandom), 8'($urandom),
                           16'($urandom), $urandom));
    endtask

    task automatic random_phase(logic [15:0] iv, int count);
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            random_word(iv);
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        sb = new();
        cycles = 0;
        stall_run = 0;
        cfg_writes = 0;
        quiet = 1'b1;
        clock_ms = '0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        out_stall <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Throttled tick, then the reset colors on every pad.
        tick_after(32'd0);
        tick_after(32'd16);
        send(make_word(MODE_IDLE, 8'd0, 24'hFFFFFF, 8'd0, 16'd0, clock_ms));
        send(make_word(MODE_IDLE, 8'd7, 24'h000000, 8'd255, 16'hFFFF, clock_ms));
        // A zero fade time ends the fade on the second tick.
        send(make_word(MODE_FLASH, 8'd3, 24'hFFFFFF, 8'd255, 16'd0, clock_ms));
        tick_after(32'd16);
        tick_after(32'd16);
        send(make_word(MODE_FLASH, 8'd5, 24'hFF00FF, 8'd128, 16'hFFFF, clock_ms));
        // Idle color on a busy pad is stored but not shown.
        send(make_word(MODE_IDLE, 8'd5, 24'h00FF00, 8'd200, 16'd0, clock_ms));
        send(make_word(MODE_FLASH, 8'd8, 24'h123456, 8'd1, 16'd5, clock_ms));
        send(make_word(MODE_IDLE, 8'd255, 24'h654321, 8'd1, 16'd5, clock_ms));
        send(make_word(2'd3, 8'd1, 24'hFFFFFF, 8'hFF, 16'hFFFF, 32'hFFFFFFFF));
        send(make_word(MODE_FLASH, 8'd1, 24'h80FF01, 8'd64, 16'd100, clock_ms));
        tick_after(32'd30);
        tick_after(32'd30);
        tick_after(32'd15);
        tick_after(32'd60);
        tick_after(32'd20000);
        // Time wraps past zero between ticks.
        clock_ms = 32'hFFFFFFF0;
        send(make_word(MODE_FLASH, 8'd2, 24'h0000FF, 8'd255, 16'd60, clock_ms));
        tick_after(32'd20);
        tick_after(32'd20);
        tick_after(32'd40);
        tick_after(32'd16);

        random_phase(16'd16, 60);
        write_interval(16'd0);
        random_phase(16'd0, 90);
        write_interval(16'hFFFF);
        random_phase(16'hFFFF, 50);
        write_interval(16'd10);
        random_phase(16'd10, 60);
        write_interval(16'd1);
        random_phase(16'd1, 50);

        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending.size() != 0)
        begin
            $error("%0d expected result words never arrived", sb.pending.size());
            sb.errors++;
        end
        $display("covered %0d input words, %0d result words, %0d interval writes",
                 sb.words_in, sb.words_out, cfg_writes);
        $display("flash, fade, idle-color, throttled tick and time wrap cases exercised");
        if (sb.errors == 0)
            $display("pad_led_flash_fade regression: pass");
        else
            $display("pad_led_flash_fade regression: fail");
        $finish;
    end
endmodule

// ===== files.f =====
src/plff_pkg.sv
src/pad_led_flash_fade.sv
sim/tb_top.sv
